// ===== rtl/core/phwa_pkg.sv =====
// phwa_pkg: types, constants and helpers for the priority heap with aging
// used by priority_heap_with_aging and tb_top
`default_nettype none
package phwa_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W = 58;
  localparam logic [15:0] AGE_LIMIT_RESET = 16'd5;
  localparam logic [1:0] PRIO_NORMAL = 2'd1;
  localparam logic [1:0] PRIO_BACKGROUND = 2'd2;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic CMD_PUSH = 1'b0;
  localparam logic [0:0] REG_AGE_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0]  prio;
    logic [15:0] id;
    logic [7:0]  pages;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  prio;
    logic [15:0] job_id;
    logic [7:0]  pages;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [1:0]  out_prio;
    logic [7:0]  out_pages;
    logic [31:0] out_stamp;
    logic [4:0]  fill;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PUSH_RD, S_PUSH_WT, S_PUSH_CMP,
    S_AGE_RD, S_AGE_WT, S_AGE_CHK,
    S_ROOT_RD, S_ROOT_WT, S_LAST_RD, S_LAST_WT,
    S_SNK_START, S_SNK_RDL, S_SNK_RDR, S_SNK_WL, S_SNK_WR, S_SNK_DEC, S_SNK_SWAP,
    S_SNK_DONE, S_OUT
  } state_t;

  function automatic logic ranks_before(entry_t x, entry_t y);
    if (x.prio != y.prio) return x.prio < y.prio;
    return x.stamp < y.stamp;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/priority_heap_with_aging.sv =====
// priority_heap_with_aging: binary min-heap job queue with aging
// depends on phwa_pkg and phwa_ram
//
// usage:
//   in_valid/in_ready carry one command item (push or pop). out_valid/out_ready
//   return exactly one result item per command. the block takes one item at a
//   time: in_ready is high only while idle and the result register is empty.
//   all work goes through one single-port heap ram, one access at a time,
//   and entries are ordered by ranks_before:
//     push: write the new entry at the end, then sift it up one level at a time
//     pop:  an aging scan over every entry, then if any job aged a
//           bottom-up rebuild by sink steps, then root removal and
//           sift-down
//   the result waits in an output register while the receiver stalls; the next
//   item is accepted once the result has been taken.
//   reset (synchronous, rst_n low) empties the queue and sets age_limit to 5;
//   heap ram contents need no clearing. age_limit is at cfg address 0.
`default_nettype none
module priority_heap_with_aging (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire phwa_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output phwa_pkg::out_item_t     out_data,
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [1:0]         cfg_paddr,
  input  wire logic [31:0]        cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);
  import phwa_pkg::*;

  state_t state_r, state_nxt;
  in_item_t cmd_r, cmd_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [15:0] age_limit_r;
  logic [IDX_W:0] pos_r, pos_nxt, pick_r, pick_nxt, k_r, k_nxt;
  entry_t a_r, a_nxt, b_r, b_nxt, best_r, best_nxt, top_r, top_nxt;
  logic touched_r, touched_nxt, rebuild_r, rebuild_nxt;
  logic ov_r;
  out_item_t od_r;
  logic done;
  logic [1:0] status;
  logic we;
  logic [IDX_W-1:0] addr;
  entry_t wdata, rdata;

  phwa_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[1:0] == {REG_AGE_LIMIT, 1'b0}) ? {16'd0, age_limit_r} : 32'd0;
  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      age_limit_r <= AGE_LIMIT_RESET;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == {REG_AGE_LIMIT, 1'b0}) begin
        age_limit_r <= cfg_pwdata[15:0];
      end
      if (done) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    pos_r <= pos_nxt;
    pick_r <= pick_nxt;
    k_r <= k_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    best_r <= best_nxt;
    top_r <= top_nxt;
    touched_r <= touched_nxt;
    rebuild_r <= rebuild_nxt;
    if (done) begin
      od_r.status <= status;
      od_r.out_id <= top_r.id;
      od_r.out_prio <= top_r.prio;
      od_r.out_pages <= top_r.pages;
      od_r.out_stamp <= top_r.stamp;
      od_r.fill <= 5'(count_r);
    end
  end

  logic [IDX_W:0] lch, rch;
  assign lch = (IDX_W+1)'({pos_r, 1'b1});
  assign rch = (IDX_W+1)'({pos_r, 1'b0} + 2);

  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    count_nxt = count_r;
    pos_nxt = pos_r;
    pick_nxt = pick_r;
    k_nxt = k_r;
    a_nxt = a_r;
    b_nxt = b_r;
    best_nxt = best_r;
    top_nxt = top_r;
    touched_nxt = touched_r;
    rebuild_nxt = rebuild_r;
    done = 1'b0;
    status = ST_OK;
    we = 1'b0;
    addr = pos_r[IDX_W-1:0];
    wdata = a_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd_nxt = in_data;
          top_nxt = '0;
          if (in_data.cmd == CMD_PUSH) begin
            if (count_r >= CNT_W'(QUEUE_DEPTH)) begin
              pos_nxt = '1;
              state_nxt = S_OUT;
            end else begin
              a_nxt = '{in_data.prio, in_data.job_id, in_data.pages, in_data.now};
              pos_nxt = (IDX_W+1)'(count_r);
              addr = count_r[IDX_W-1:0];
              we = 1'b1;
              wdata = '{in_data.prio, in_data.job_id, in_data.pages, in_data.now};
              count_nxt = count_r + 1'b1;
              state_nxt = S_PUSH_RD;
            end
          end else if (count_r == '0) begin
            pos_nxt = '1;
            state_nxt = S_OUT;
          end else begin
            k_nxt = '0;
            touched_nxt = 1'b0;
            state_nxt = S_AGE_RD;
          end
        end
      end
      S_PUSH_RD: begin
        if (pos_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          pick_nxt = (pos_r - 1'b1) >> 1;
          addr = IDX_W'((pos_r - 1'b1) >> 1);
          state_nxt = S_PUSH_WT;
        end
      end
      S_PUSH_WT: begin
        addr = pick_r[IDX_W-1:0];
        b_nxt = rdata;
        state_nxt = S_PUSH_CMP;
      end
      S_PUSH_CMP: begin
        if (ranks_before(a_r, b_r)) begin
          we = 1'b1;
          addr = pos_r[IDX_W-1:0];
          wdata = b_r;
          pos_nxt = pick_r;
          state_nxt = S_SNK_DONE;
          rebuild_nxt = 1'b0;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_AGE_RD: begin
        addr = k_r[IDX_W-1:0];
        state_nxt = S_AGE_WT;
      end
      S_AGE_WT: begin
        addr = k_r[IDX_W-1:0];
        a_nxt = rdata;
        state_nxt = S_AGE_CHK;
      end
      S_AGE_CHK: begin
        addr = k_r[IDX_W-1:0];
        if (a_r.prio == PRIO_BACKGROUND && cmd_r.now >= a_r.stamp &&
            (cmd_r.now - a_r.stamp) >= {16'd0, age_limit_r}) begin
          we = 1'b1;
          wdata = a_r;
          wdata.prio = PRIO_NORMAL;
          touched_nxt = 1'b1;
        end
        if (k_r + 1'b1 >= (IDX_W+1)'(count_r)) begin
          if (touched_nxt && (count_r >> 1) != '0) begin
            k_nxt = (IDX_W+1)'(count_r >> 1) - 1'b1;
            pos_nxt = (IDX_W+1)'(count_r >> 1) - 1'b1;
            rebuild_nxt = 1'b1;
            state_nxt = S_SNK_START;
          end else begin
            state_nxt = S_ROOT_RD;
          end
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_AGE_RD;
        end
      end
      S_ROOT_RD: begin
        addr = '0;
        state_nxt = S_ROOT_WT;
      end
      S_ROOT_WT: begin
        top_nxt = rdata;
        count_nxt = count_r - 1'b1;
        state_nxt = S_LAST_RD;
      end
      S_LAST_RD: begin
        addr = count_r[IDX_W-1:0];
        state_nxt = S_LAST_WT;
      end
      S_LAST_WT: begin
        addr = '0;
        we = 1'b1;
        wdata = rdata;
        pos_nxt = '0;
        rebuild_nxt = 1'b0;
        state_nxt = S_SNK_START;
      end
      S_SNK_START: begin
        state_nxt = S_SNK_RDL;
      end
      S_SNK_RDL: begin
        addr = pos_r[IDX_W-1:0];
        state_nxt = S_SNK_WL;
      end
      S_SNK_WL: begin
        a_nxt = rdata;
        best_nxt = rdata;
        pick_nxt = pos_r;
        if (lch < (IDX_W+1)'(count_r)) begin
          addr = lch[IDX_W-1:0];
          state_nxt = S_SNK_RDR;
        end else begin
          state_nxt = S_SNK_DEC;
        end
      end
      S_SNK_RDR: begin
        addr = lch[IDX_W-1:0];
        if (ranks_before(rdata, best_r)) begin
          best_nxt = rdata;
          pick_nxt = lch;
        end
        if (rch < (IDX_W+1)'(count_r)) begin
          addr = rch[IDX_W-1:0];
          state_nxt = S_SNK_WR;
        end else begin
          state_nxt = S_SNK_DEC;
        end
      end
      S_SNK_WR: begin
        if (ranks_before(rdata, best_r)) begin
          best_nxt = rdata;
          pick_nxt = rch;
        end
        state_nxt = S_SNK_DEC;
      end
      S_SNK_DEC: begin
        if (pick_r == pos_r) begin
          state_nxt = S_SNK_DONE;
        end else begin
          we = 1'b1;
          addr = pos_r[IDX_W-1:0];
          wdata = best_r;
          state_nxt = S_SNK_SWAP;
        end
      end
      S_SNK_SWAP: begin
        we = 1'b1;
        addr = pick_r[IDX_W-1:0];
        wdata = a_r;
        pos_nxt = pick_r;
        state_nxt = S_SNK_RDL;
      end
      S_SNK_DONE: begin
        if (cmd_r.cmd == CMD_PUSH) begin
          we = 1'b1;
          addr = pos_r[IDX_W-1:0];
          wdata = a_r;
          state_nxt = S_PUSH_RD;
        end else if (rebuild_r) begin
          if (k_r == '0) begin
            state_nxt = S_ROOT_RD;
          end else begin
            k_nxt = k_r - 1'b1;
            pos_nxt = k_r - 1'b1;
            state_nxt = S_SNK_RDL;
          end
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        done = 1'b1;
        if (pos_r == '1) begin
          status = (cmd_r.cmd == CMD_PUSH) ? ST_FULL : ST_EMPTY;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/core/phwa_ram.sv =====
// phwa_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module phwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for priority_heap_with_aging
// drives push/pop items and age_limit writes, predicts results with a local heap model
// depends on phwa_pkg and the priority_heap_with_aging rtl
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import phwa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [1:0] PRIO_URGENT = 2'd0;
  localparam logic [1:0] PRIO_BAD = 2'd3;
  localparam logic CMD_POP = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  priority_heap_with_aging dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  entry_t jobs[QUEUE_DEPTH];
  int job_total;
  logic [15:0] aging_limit;
  out_item_t pending_results[$];
  int errors = 0;
  int pushes_sent = 0;
  int pops_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit stall_enable = 1'b1;
  bit gap_enable = 1'b1;

  function automatic bit job_better(entry_t x, entry_t y);
    if (x.prio != y.prio) return x.prio < y.prio;
    return x.stamp < y.stamp;
  endfunction

  function automatic void swap_jobs(int p, int q);
    entry_t t;
    t = jobs[p];
    jobs[p] = jobs[q];
    jobs[q] = t;
  endfunction

  function automatic void sink_job(int pos);
    int l, r, pick;
    forever begin
      l = 2 * pos + 1;
      r = 2 * pos + 2;
      pick = pos;
      if (l < job_total && job_better(jobs[l], jobs[pick])) pick = l;
      if (r < job_total && job_better(jobs[r], jobs[pick])) pick = r;
      if (pick == pos) break;
      swap_jobs(pos, pick);
      pos = pick;
    end
  endfunction

  function automatic out_item_t predict_queue_step(in_item_t it);
    out_item_t res;
    entry_t top;
    int pos, up;
    bit touched;
    res = '0;
    top = '0;
    if (it.cmd == CMD_PUSH) begin
      if (job_total >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = job_total;
        jobs[pos] = '{prio: it.prio, id: it.job_id, pages: it.pages, stamp: it.now};
        job_total++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!job_better(jobs[pos], jobs[up])) break;
          swap_jobs(pos, up);
          pos = up;
        end
      end
    end else if (job_total == 0) begin
      res.status = ST_EMPTY;
    end else begin
      touched = 1'b0;
      for (int k = 0; k < job_total; k++) begin
        if (jobs[k].prio == PRIO_BACKGROUND && it.now >= jobs[k].stamp &&
            (it.now - jobs[k].stamp) >= {16'd0, aging_limit}) begin
          jobs[k].prio = PRIO_NORMAL;
          touched = 1'b1;
        end
      end
      if (touched)
        for (int k = job_total / 2 - 1; k >= 0; k--) sink_job(k);
      top = jobs[0];
      job_total--;
      jobs[0] = jobs[job_total];
      sink_job(0);
      res.status = ST_OK;
    end
    res.out_id = top.id;
    res.out_prio = top.prio;
    res.out_pages = top.pages;
    res.out_stamp = top.stamp;
    res.fill = job_total[4:0];
    return res;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = gap_enable ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_queue_step(it));
    if (it.cmd == CMD_PUSH) pushes_sent++;
    else pops_sent++;
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_job(logic [1:0] p, logic [15:0] id, logic [7:0] pg, logic [31:0] t);
    send_item('{cmd: CMD_PUSH, prio: p, job_id: id, pages: pg, now: t});
  endtask

  task automatic pop_job(logic [31:0] t);
    send_item('{cmd: CMD_POP, prio: 2'($urandom), job_id: 16'($urandom),
                pages: 8'($urandom), now: t});
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_age_limit(logic [15:0] v);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {REG_AGE_LIMIT, 1'b0} << 1;
    cfg_pwdata <= {16'($urandom), v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    aging_limit = v;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_queue(logic [31:0] t);
    while (job_total > 0) pop_job(t);
  endtask

  task automatic test_directed_extremes();
    pop_job(32'hFFFF_FFFF);
    push_job(PRIO_BACKGROUND, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
    push_job(PRIO_URGENT, 16'h0000, 8'h00, 32'h0000_0000);
    push_job(PRIO_BAD, 16'hA5A5, 8'h5A, 32'd10);
    push_job(PRIO_NORMAL, 16'h1234, 8'h80, 32'd3);
    push_job(PRIO_BACKGROUND, 16'h4321, 8'h01, 32'd100);
    pop_job(32'd0);
    pop_job(32'd1000);
    pop_job(32'd50);
    drain_queue(32'd0);
    pop_job(32'd0);
  endtask

  task automatic test_full_queue();
    for (int i = 0; i < QUEUE_DEPTH + 2; i++)
      push_job(2'($urandom_range(0, 3)), 16'(i), 8'($urandom), 32'($urandom_range(0, 40)));
    drain_queue(32'd20);
  endtask

  task automatic test_aging_limits();
    write_age_limit(16'd0);
    push_job(PRIO_BACKGROUND, 16'd1, 8'd1, 32'd500);
    push_job(PRIO_BACKGROUND, 16'd2, 8'd2, 32'd5);
    push_job(PRIO_NORMAL, 16'd3, 8'd3, 32'd9);
    pop_job(32'd100);
    drain_queue(32'd100);
    write_age_limit(16'hFFFF);
    push_job(PRIO_BACKGROUND, 16'd4, 8'd4, 32'd0);
    push_job(PRIO_NORMAL, 16'd5, 8'd5, 32'd1);
    pop_job(32'h0000_FFFE);
    pop_job(32'h0000_FFFF);
    drain_queue(32'h0001_0000);
  endtask

  task automatic random_burst(int n, logic [31:0] span);
    logic [31:0] clock_now;
    clock_now = $urandom;
    for (int i = 0; i < n; i++) begin
      clock_now += $urandom_range(0, span);
      if ($urandom_range(0, 19) == 0)
        send_item(in_item_t'({$urandom, $urandom}));
      else if ($urandom_range(0, 99) < (job_total < 8 ? 65 : 40))
        push_job(($urandom_range(0, 15) == 0) ? PRIO_BAD : 2'($urandom_range(0, 2)),
                 16'($urandom), 8'($urandom),
                 ($urandom_range(0, 9) == 0) ? clock_now + 32'd50 : clock_now);
      else
        pop_job(clock_now);
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] limits[4] = '{16'd0, 16'd5, 16'd40, 16'hFFFF};
    for (int ph = 0; ph < 8; ph++) begin
      write_age_limit(ph < 4 ? limits[ph] : 16'($urandom_range(0, 64)));
      stall_enable = (ph != 2);
      gap_enable = (ph != 3);
      random_burst(240, ph == 5 ? 32'hFFFF_FFFF : 32'd12);
      if (ph == 4) wait_drained();
    end
    stall_enable = 1'b1;
    gap_enable = 1'b1;
  endtask

  initial begin : stall_proc
    int wait_n;
    forever begin
      wait_n = stall_enable ? $urandom_range(0, 18) : 0;
      if ($urandom_range(0, 3) == 0) wait_n = 0;
      out_ready <= 1'b0;
      repeat (wait_n) @(posedge clk);
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data !== want) begin
          $display("%0t: result mismatch expected %p actual %p", $time, want, out_data);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    job_total = 0;
    aging_limit = AGE_LIMIT_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_full_queue();
    test_aging_limits();
    test_random_traffic();
    wait_drained();
    $display("covered %0d pushes and %0d pops, %0d results checked,", pushes_sent,
             pops_sent, results_seen);
    $display("with full and empty queues, aging limits 0 to 65535 and random stalls");
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
